FILE: hdl/fifo_with_key_removal_unit_macros.svh
// Assertion macros used by the queue's top-level RTL file.
// Each macro checks against the block clock and is off while reset is held.
`ifndef FIFO_WITH_KEY_REMOVAL_UNIT_MACROS_SVH
`define FIFO_WITH_KEY_REMOVAL_UNIT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define FWKR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed in %m");

// The consequence must hold in the cycle after the condition.
`define FWKR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed in %m");

`endif

FILE: hdl/fwkr_pkg.sv
package fwkr_pkg;

	// Defaults for the top-level parameters.
	localparam int unsigned DEPTH_DEFAULT    = 16;
	localparam int unsigned KEY_BITS_DEFAULT = 16;
	localparam int unsigned VALUE_BITS       = 32;

	// Operation carried with each input beat.
	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_SPARE  = 2'd3
	} mode_t;

	// Outcome reported with each result beat.
	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// What the datapath does to the store when an operation is applied.
	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_PUSH,
		ACT_POP,
		ACT_REMOVE
	} act_t;

	// Controller to datapath.
	typedef struct packed {
		logic    load;
		logic    apply;
		act_t    act;
		status_t status;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		mode_t mode;
		logic  full;
		logic  empty;
		logic  hit;
	} ctrl_stat_t;

endpackage

FILE: hdl/fwkr_ctrl.sv
module fwkr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  fwkr_pkg::ctrl_stat_t   stat,
	output fwkr_pkg::ctrl_cmd_t    cmd
);
	import fwkr_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_APPLY
	} state_t;

	state_t state_q;
	logic   out_free;

	// The result register can take a new result when empty or being drained.
	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == S_IDLE);

	// Decide the store action and the reported status from the datapath flags.
	always_comb begin
		cmd.load   = s_tvalid && s_tready;
		cmd.apply  = (state_q == S_APPLY) && out_free;
		cmd.act    = ACT_NONE;
		cmd.status = ST_DONE;
		unique case (stat.mode)
			MODE_PUSH: begin
				if (stat.full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.act = ACT_PUSH;
				end
			end
			MODE_POP: begin
				if (stat.empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.act = ACT_POP;
				end
			end
			MODE_REMOVE: begin
				if (stat.hit) begin
					cmd.act = ACT_REMOVE;
				end else begin
					cmd.status = ST_NOT_FOUND;
				end
			end
			default: begin
				cmd.act    = ACT_NONE;
				cmd.status = ST_DONE;
			end
		endcase
	end

	// State and the result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			// A new result replaces one that is handed over in the same cycle.
			if (cmd.apply) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (cmd.apply) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/fwkr_dp.sv
module fwkr_dp #(
	parameter int unsigned DEPTH    = 16,
	parameter int unsigned KEY_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  fwkr_pkg::ctrl_cmd_t                      cmd,
	output fwkr_pkg::ctrl_stat_t                     stat,
	input  fwkr_pkg::mode_t                          mode,
	input  logic [KEY_BITS-1:0]                      item_key,
	input  logic [fwkr_pkg::VALUE_BITS-1:0]          item_value,
	output fwkr_pkg::status_t                        status,
	output logic [KEY_BITS-1:0]                      taken_key,
	output logic [fwkr_pkg::VALUE_BITS-1:0]          taken_value,
	output logic                                     oldest_valid,
	output logic [KEY_BITS-1:0]                      oldest_key,
	output logic [fwkr_pkg::VALUE_BITS-1:0]          oldest_value,
	output logic [$clog2(DEPTH+1)-1:0]               entry_count
);
	import fwkr_pkg::*;

	localparam int unsigned CountBits = $clog2(DEPTH + 1);

	// Entry store, kept oldest first at position zero.
	logic [KEY_BITS-1:0]   key_q [DEPTH];
	logic [VALUE_BITS-1:0] val_q [DEPTH];
	logic [CountBits-1:0]  count_q;

	// Captured item and its compare result.
	mode_t                 mode_q;
	logic [KEY_BITS-1:0]   in_key_q;
	logic [VALUE_BITS-1:0] in_val_q;
	logic [DEPTH-1:0]      match_q;

	// Result registers.
	status_t               status_q;
	logic [KEY_BITS-1:0]   taken_key_q;
	logic [VALUE_BITS-1:0] taken_val_q;

	logic [DEPTH-1:0]      match_d;
	logic [DEPTH-1:0]      match_rev;
	logic [DEPTH-1:0]      rev_low;
	logic [DEPTH-1:0]      newest_hot;
	logic [DEPTH-1:0]      sel_hot;
	logic [DEPTH-1:0]      shift_mask;
	logic                  is_take;
	logic [KEY_BITS-1:0]   sel_key;
	logic [VALUE_BITS-1:0] sel_val;

	// Compare every held entry against the incoming key in parallel.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match_d[i] = (CountBits'(i) < count_q) && (key_q[i] == item_key);
		end
	end

	// Newest match: isolate the highest set bit through a bit reversal.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match_rev[i] = match_q[DEPTH-1-i];
		end
		rev_low = match_rev & (~match_rev + DEPTH'(1));
		for (int i = 0; i < DEPTH; i++) begin
			newest_hot[i] = rev_low[DEPTH-1-i];
		end
	end

	// Position taken out and the entries that move down to close the gap.
	assign is_take    = (cmd.act == ACT_POP) || (cmd.act == ACT_REMOVE);
	assign sel_hot    = (cmd.act == ACT_POP) ? DEPTH'(1) : newest_hot;
	assign shift_mask = ~(sel_hot - DEPTH'(1));

	// Read out the taken entry with a one-hot select.
	always_comb begin
		sel_key = '0;
		sel_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_key = sel_key | (key_q[i] & {KEY_BITS{sel_hot[i]}});
			sel_val = sel_val | (val_q[i] & {VALUE_BITS{sel_hot[i]}});
		end
	end

	// Per-entry update: write on push, move down on removal.
	for (genvar g = 0; g < DEPTH; g++) begin : g_entry
		logic [KEY_BITS-1:0]   up_key;
		logic [VALUE_BITS-1:0] up_val;

		if (g == DEPTH - 1) begin : g_last
			assign up_key = key_q[g];
			assign up_val = val_q[g];
		end else begin : g_inner
			assign up_key = key_q[g+1];
			assign up_val = val_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.apply) begin
				if ((cmd.act == ACT_PUSH) && (count_q == CountBits'(g))) begin
					key_q[g] <= in_key_q;
					val_q[g] <= in_val_q;
				end else if (is_take && shift_mask[g]) begin
					key_q[g] <= up_key;
					val_q[g] <= up_val;
				end
			end
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.apply) begin
			if (cmd.act == ACT_PUSH) begin
				count_q <= count_q + CountBits'(1);
			end else if (is_take) begin
				count_q <= count_q - CountBits'(1);
			end
		end
	end

	// Item capture and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			in_key_q <= item_key;
			in_val_q <= item_value;
			match_q  <= match_d;
		end
		if (cmd.apply) begin
			status_q    <= cmd.status;
			taken_key_q <= is_take ? sel_key : '0;
			taken_val_q <= is_take ? sel_val : '0;
		end
	end

	assign stat.mode  = mode_q;
	assign stat.full  = (count_q == CountBits'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.hit   = |match_q;

	// The store only changes when no result is waiting or the waiting one is handed over,
	// so the peek fields come straight from position zero.
	assign status       = status_q;
	assign taken_key    = taken_key_q;
	assign taken_value  = taken_val_q;
	assign oldest_valid = (count_q != '0);
	assign oldest_key   = oldest_valid ? key_q[0] : '0;
	assign oldest_value = oldest_valid ? val_q[0] : '0;
	assign entry_count  = count_q;

endmodule

FILE: hdl/fifo_with_key_removal_unit.sv
// Bounded key/value queue with push, pop of the oldest entry, and removal of the
// newest entry whose key matches. Each input beat yields one result beat with a
// status, the removed entry, the oldest entry after the operation and the count.
// An item is first accepted and its key compared against every held entry at once;
// then the push, pop or removal is applied, closing any gap with a one-place shift
// of the newer entries, and the result register is loaded. The apply step waits
// while an earlier result is still unread, and a new item is accepted only after
// the last one has been applied. The store needs no clearing after reset.
`include "fifo_with_key_removal_unit_macros.svh"

module fifo_with_key_removal_unit #(
	parameter int unsigned DEPTH    = fwkr_pkg::DEPTH_DEFAULT,
	parameter int unsigned KEY_BITS = fwkr_pkg::KEY_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	// Input beats.
	input  logic                                                      s_tvalid,
	output logic                                                      s_tready,
	// item_key, item_value
	input  logic [((KEY_BITS+fwkr_pkg::VALUE_BITS+7)/8)*8-1:0]       s_tdata,
	// mode
	input  logic [1:0]                                                s_tuser,
	// Result beats.
	output logic                                                      m_tvalid,
	input  logic                                                      m_tready,
	// taken_key, taken_value, oldest_valid, oldest_key, oldest_value, entry_count
	output logic [((2*KEY_BITS+2*fwkr_pkg::VALUE_BITS+1+$clog2(DEPTH+1)+7)/8)*8-1:0]
		m_tdata,
	// status
	output logic [1:0]                                                m_tuser
);
	import fwkr_pkg::*;

	localparam int unsigned CountBits   = $clog2(DEPTH + 1);
	localparam int unsigned OutBits     = 2*KEY_BITS + 2*VALUE_BITS + 1 + CountBits;
	localparam int unsigned OutDataBits = ((OutBits + 7) / 8) * 8;

	ctrl_cmd_t             cmd;
	ctrl_stat_t            stat;
	status_t               status;
	logic [KEY_BITS-1:0]   taken_key;
	logic [VALUE_BITS-1:0] taken_value;
	logic                  oldest_valid;
	logic [KEY_BITS-1:0]   oldest_key;
	logic [VALUE_BITS-1:0] oldest_value;
	logic [CountBits-1:0]  entry_count;

	// Sequencing and result handshake.
	fwkr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Entry store, key compare and result registers.
	fwkr_dp #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode_t'(s_tuser)),
		.item_key     (s_tdata[KEY_BITS-1:0]),
		.item_value   (s_tdata[KEY_BITS +: VALUE_BITS]),
		.status       (status),
		.taken_key    (taken_key),
		.taken_value  (taken_value),
		.oldest_valid (oldest_valid),
		.oldest_key   (oldest_key),
		.oldest_value (oldest_value),
		.entry_count  (entry_count)
	);

	// Result beat packing, first field in the lowest bits.
	assign m_tuser = status;
	assign m_tdata = OutDataBits'({entry_count, oldest_value, oldest_key, oldest_valid,
		taken_value, taken_key});

	// Checks on the sequencing and on the reported state.
	`FWKR_ASSERT_NEXT(a_one_item_at_a_time, s_tvalid && s_tready, !s_tready)
	`FWKR_ASSERT_NOW(a_count_in_range, m_tvalid, entry_count <= CountBits'(DEPTH))
	`FWKR_ASSERT_NOW(a_full_means_full, m_tvalid && (status == ST_FULL), entry_count == CountBits'(DEPTH))
	`FWKR_ASSERT_NOW(a_empty_means_empty, m_tvalid && (status == ST_EMPTY), (entry_count == '0) && !oldest_valid)

endmodule

FILE: tb/fifo_with_key_removal_unit_tb.sv
`timescale 1ns / 100ps

module fifo_with_key_removal_unit_tb;
	import fwkr_pkg::*;

	localparam int unsigned DEPTH    = DEPTH_DEFAULT;
	localparam int unsigned KEY_BITS = KEY_BITS_DEFAULT;
	localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
	localparam int unsigned S_BITS   = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
	localparam int unsigned M_BITS   =
		((2 * KEY_BITS + 2 * VALUE_BITS + 1 + CNT_BITS + 7) / 8) * 8;
	localparam int unsigned RANDOM_ITEMS = 650;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	// Phase kinds for the random stimulus.
	localparam int PHASE_FILL  = 0;
	localparam int PHASE_DRAIN = 1;
	localparam int PHASE_MIXED = 2;

	// One result beat, unpacked.
	typedef struct {
		status_t              status;
		logic [KEY_BITS-1:0]  taken_key;
		logic [31:0]          taken_value;
		logic                 oldest_valid;
		logic [KEY_BITS-1:0]  oldest_key;
		logic [31:0]          oldest_value;
		logic [CNT_BITS-1:0]  entry_count;
	} queue_result_t;

	// Shadow copy of the queue; predicts the result of every accepted item.
	class queue_scoreboard;
		logic [KEY_BITS-1:0] slot_key[DEPTH];
		logic [31:0]         slot_value[DEPTH];
		int unsigned         held;
		queue_result_t       awaited[$];
		int unsigned         fail_count;

		function new();
			held = 0;
			fail_count = 0;
		endfunction

		// Takes out the entry at pos and moves every newer entry down one place.
		function void take_at(int unsigned pos);
			for (int unsigned i = pos; i + 1 < held; i++) begin
				slot_key[i]   = slot_key[i + 1];
				slot_value[i] = slot_value[i + 1];
			end
			held--;
		endfunction

		function void note_item(mode_t mode, logic [KEY_BITS-1:0] key, logic [31:0] value);
			queue_result_t res;
			int            pos;
			res.status      = ST_DONE;
			res.taken_key   = '0;
			res.taken_value = '0;
			case (mode)
				MODE_PUSH: begin
					if (held >= DEPTH) begin
						res.status = ST_FULL;
					end else begin
						slot_key[held]   = key;
						slot_value[held] = value;
						held++;
					end
				end
				MODE_POP: begin
					if (held == 0) begin
						res.status = ST_EMPTY;
					end else begin
						res.taken_key   = slot_key[0];
						res.taken_value = slot_value[0];
						take_at(0);
					end
				end
				MODE_REMOVE: begin
					// Search runs from the newest entry towards the oldest.
					pos = -1;
					for (int i = int'(held) - 1; i >= 0 && pos < 0; i--) begin
						if (slot_key[i] == key) begin
							pos = i;
						end
					end
					if (pos < 0) begin
						res.status = ST_NOT_FOUND;
					end else begin
						res.taken_key   = slot_key[pos];
						res.taken_value = slot_value[pos];
						take_at(pos);
					end
				end
				default: begin
				end
			endcase
			res.oldest_valid = (held > 0);
			res.oldest_key   = (held > 0) ? slot_key[0] : '0;
			res.oldest_value = (held > 0) ? slot_value[0] : '0;
			res.entry_count  = held[CNT_BITS-1:0];
			awaited.push_back(res);
		endfunction

		function void check_result(queue_result_t got);
			queue_result_t want;
			if (awaited.size() == 0) begin
				$error("result beat with no item outstanding");
				fail_count++;
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fail_count++;
			end
			if (got.taken_key !== want.taken_key) begin
				$error("taken_key: expected %h, got %h", want.taken_key, got.taken_key);
				fail_count++;
			end
			if (got.taken_value !== want.taken_value) begin
				$error("taken_value: expected %h, got %h", want.taken_value, got.taken_value);
				fail_count++;
			end
			if (got.oldest_valid !== want.oldest_valid) begin
				$error("oldest_valid: expected %b, got %b", want.oldest_valid,
					got.oldest_valid);
				fail_count++;
			end
			if (got.oldest_key !== want.oldest_key) begin
				$error("oldest_key: expected %h, got %h", want.oldest_key, got.oldest_key);
				fail_count++;
			end
			if (got.oldest_value !== want.oldest_value) begin
				$error("oldest_value: expected %h, got %h", want.oldest_value,
					got.oldest_value);
				fail_count++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, got %0d", want.entry_count,
					got.entry_count);
				fail_count++;
			end
		endfunction

		// Key of a random entry that is currently held; only called when held > 0.
		function logic [KEY_BITS-1:0] held_key();
			return slot_key[$urandom_range(0, held - 1)];
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_BITS-1:0]   s_tdata = '0;   // item_key, item_value
	logic [1:0]          s_tuser = '0;   // mode
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_BITS-1:0]   m_tdata;        // taken_key, taken_value, oldest_valid,
	                                     // oldest_key, oldest_value, entry_count
	logic [1:0]          m_tuser;        // status

	queue_scoreboard     sb = new();
	logic [KEY_BITS-1:0] key_pool[8];
	bit                  tx_steady = 1'b0;
	bit                  rx_steady = 1'b0;
	int unsigned         rx_stall_left = 0;

	fifo_with_key_removal_unit #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 25);
	endfunction

	// Offers one beat and returns once it has been accepted.
	task automatic send_item(mode_t mode, logic [KEY_BITS-1:0] key, logic [31:0] value);
		int unsigned gap;
		gap = tx_steady ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= S_BITS'({value, key});
		do @(posedge clk); while (!s_tready);
		sb.note_item(mode, key, value);
	endtask

	function automatic logic [KEY_BITS-1:0] pick_key();
		if ($urandom_range(0, 99) < 70) begin
			return key_pool[$urandom_range(0, 7)];
		end
		return KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
	endfunction

	function automatic mode_t pick_mode(int phase);
		int unsigned r;
		int unsigned push_lim;
		int unsigned pop_lim;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			return MODE_SPARE;
		end
		case (phase)
			PHASE_FILL:  begin push_lim = 65; pop_lim = 80; end
			PHASE_DRAIN: begin push_lim = 25; pop_lim = 60; end
			default:     begin push_lim = 45; pop_lim = 70; end
		endcase
		if (r < push_lim) begin
			return MODE_PUSH;
		end else if (r < pop_lim) begin
			return MODE_POP;
		end
		return MODE_REMOVE;
	endfunction

	// Result side: random stalls, checks every accepted beat.
	always @(posedge clk) begin
		queue_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status       = status_t'(m_tuser);
			got.taken_key    = m_tdata[KEY_BITS-1:0];
			got.taken_value  = m_tdata[KEY_BITS +: 32];
			got.oldest_valid = m_tdata[KEY_BITS + 32];
			got.oldest_key   = m_tdata[KEY_BITS + 33 +: KEY_BITS];
			got.oldest_value = m_tdata[2 * KEY_BITS + 33 +: 32];
			got.entry_count  = m_tdata[2 * KEY_BITS + 65 +: CNT_BITS];
			sb.check_result(got);
		end
		if (rx_stall_left > 0) begin
			rx_stall_left <= rx_stall_left - 1;
			m_tready <= 1'b0;
		end else if (!rx_steady && $urandom_range(0, 99) < 30) begin
			rx_stall_left <= idle_len();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int          phase;
		mode_t       mode;
		logic [KEY_BITS-1:0] key;

		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = KEY_BITS'(16'h8001);
		key_pool[3] = KEY_BITS'(16'h7FFE);
		for (int i = 4; i < 8; i++) begin
			key_pool[i] = KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-queue cases, extremes, duplicate keys, head and newest hits.
		send_item(MODE_POP, '0, 32'h0);
		send_item(MODE_REMOVE, '0, 32'h0);
		send_item(MODE_SPARE, '1, 32'hFFFF_FFFF);
		send_item(MODE_PUSH, '0, 32'h8000_0000);
		send_item(MODE_PUSH, '1, 32'h7FFF_FFFF);
		send_item(MODE_PUSH, KEY_BITS'(16'h1234), 32'hFFFF_FFFF);
		send_item(MODE_PUSH, '1, 32'h0000_0000);
		// Duplicate key: the newer copy must go first.
		send_item(MODE_REMOVE, '1, 32'h0);
		// Match at the oldest position.
		send_item(MODE_REMOVE, '0, 32'h0);
		send_item(MODE_REMOVE, KEY_BITS'(16'hBEEF), 32'h0);
		send_item(MODE_SPARE, '0, 32'h0);
		send_item(MODE_POP, '0, 32'h0);

		// Fill to the brim, then push once more against a full store.
		while (sb.held < DEPTH) begin
			send_item(MODE_PUSH, KEY_BITS'(sb.held * 16'h1111), $urandom());
		end
		send_item(MODE_PUSH, KEY_BITS'(16'h5A5A), 32'h1234_5678);
		send_item(MODE_SPARE, '1, 32'h0);
		send_item(MODE_REMOVE, sb.slot_key[DEPTH / 2], 32'h0);
		send_item(MODE_REMOVE, sb.slot_key[sb.held - 1], 32'h0);

		// Random phases that push the queue up, drain it, or hover.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0) begin
				phase     = $urandom_range(PHASE_FILL, PHASE_MIXED);
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			mode = pick_mode(phase);
			if (mode == MODE_REMOVE && sb.held > 0 && $urandom_range(0, 99) < 70) begin
				key = sb.held_key();
			end else begin
				key = pick_key();
			end
			send_item(mode, key, $urandom());
		end
		s_tvalid <= 1'b0;
		rx_steady = 1'b0;

		while (sb.awaited.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (sb.fail_count == 0 && sb.awaited.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
